// ===== hw/rtl/chfx_pkg.sv =====
// ============================================================================
// chfx_pkg: shared types and constants of the compass heading block
// Fixed-point formats, the CORDIC arctangent table, reset values of the
// offset and declination registers and the register index codes.
// ============================================================================
package chfx_pkg;

   // Heading resolution: 2^-ANGLE_FRAC_BITS degree per LSB.
   localparam int ANGLE_FRAC_BITS = 6;
   // Number of CORDIC micro-rotations, one pipeline stage each.
   localparam int CORDIC_STAGES   = 16;
   localparam int TABLE_LEN       = 24;

   // Field widths.
   localparam int READING_W = 13;
   localparam int OFFSET_W  = 12;
   localparam int DECL_W    = 14;
   localparam int HEADING_W = 15;
   localparam int DIFF_W    = 14;   // reading minus offset
   localparam int DATA_W    = 14;   // widest register

   // Internal formats.
   localparam int ZFRAC     = 24;   // angle: degrees times 2^24
   localparam int Z_W       = 34;
   localparam int VEC_FRAC  = 20;   // vector: integer times 2^20
   localparam int VEC_W     = 36;
   localparam int T_W       = 40;   // heading before rounding
   localparam int OUT_SHIFT = ZFRAC - ANGLE_FRAC_BITS;

   // Cycles from an accepted item to its result strobe.
   localparam int LATENCY   = CORDIC_STAGES + 5;

   localparam logic signed [OFFSET_W-1:0] X_OFFSET_RST = 12'sd10;
   localparam logic signed [OFFSET_W-1:0] Y_OFFSET_RST = -12'sd182;
   localparam logic signed [DECL_W-1:0]   DECL_RST     = 14'sd0;

   localparam logic signed [Z_W-1:0] Z_DEG_90  = Z_W'(longint'(90) <<< ZFRAC);
   localparam logic signed [Z_W-1:0] Z_DEG_180 = Z_W'(longint'(180) <<< ZFRAC);

   localparam logic signed [T_W-1:0] T_DEG_90  = T_W'(longint'(90) <<< ZFRAC);
   localparam logic signed [T_W-1:0] T_DEG_360 = T_W'(longint'(360) <<< ZFRAC);
   localparam logic signed [T_W-1:0] T_ROUND   = T_W'(longint'(1) <<< (OUT_SHIFT - 1));

   typedef enum logic [1:0] {
      CSR_X_OFFSET    = 2'd0,
      CSR_Y_OFFSET    = 2'd1,
      CSR_DECLINATION = 2'd2
   } chfx_csr_type;

   // One CORDIC pipeline slot. A fixed item already has its final angle.
   typedef struct packed {
      logic                    valid;
      logic                    fixed;
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [Z_W-1:0]   z;
   } chfx_stage_type;

   // atan(2^-i) in degrees times 2^24, rounded to nearest.
   function automatic logic signed [Z_W-1:0] atan_deg(input int idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         0:       val = 34'sd754974720;
         1:       val = 34'sd445687602;
         2:       val = 34'sd235489088;
         3:       val = 34'sd119537938;
         4:       val = 34'sd60000934;
         5:       val = 34'sd30029717;
         6:       val = 34'sd15018523;
         7:       val = 34'sd7509720;
         8:       val = 34'sd3754917;
         9:       val = 34'sd1877466;
         10:      val = 34'sd938734;
         11:      val = 34'sd469367;
         12:      val = 34'sd234684;
         13:      val = 34'sd117342;
         14:      val = 34'sd58671;
         15:      val = 34'sd29335;
         16:      val = 34'sd14668;
         17:      val = 34'sd7334;
         18:      val = 34'sd3667;
         19:      val = 34'sd1833;
         20:      val = 34'sd917;
         21:      val = 34'sd458;
         22:      val = 34'sd229;
         23:      val = 34'sd115;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== hw/rtl/chfx_cordic.sv =====
// ============================================================================
// chfx_cordic: pipelined vectoring CORDIC
// One micro-rotation per register stage; drives y toward zero and
// accumulates the rotation angle in degrees.
// ============================================================================
module chfx_cordic
   import chfx_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  chfx_stage_type in_stage,
   output chfx_stage_type out_stage
);

   chfx_stage_type link    [CORDIC_STAGES+1];
   chfx_stage_type stage_in[CORDIC_STAGES];
   chfx_stage_type stage_ff[CORDIC_STAGES];

   always_comb begin
      link[0] = in_stage;
      for (int s = 0; s < CORDIC_STAGES; s++) begin
         link[s+1] = stage_ff[s];
      end
   end

   // Each stage rotates by atan(2^-s); shifts are arithmetic (floor).
   always_comb begin
      for (int s = 0; s < CORDIC_STAGES; s++) begin
         stage_in[s] = link[s];
         if (!link[s].y[VEC_W-1] && (link[s].y != '0)) begin
            stage_in[s].x = link[s].x + (link[s].y >>> s);
            stage_in[s].y = link[s].y - (link[s].x >>> s);
            if (!link[s].fixed) begin
               stage_in[s].z = link[s].z + atan_deg(s);
            end
         end else begin
            stage_in[s].x = link[s].x - (link[s].y >>> s);
            stage_in[s].y = link[s].y + (link[s].x >>> s);
            if (!link[s].fixed) begin
               stage_in[s].z = link[s].z - atan_deg(s);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < CORDIC_STAGES; s++) begin
         stage_ff[s].fixed <= stage_in[s].fixed;
         stage_ff[s].x     <= stage_in[s].x;
         stage_ff[s].y     <= stage_in[s].y;
         stage_ff[s].z     <= stage_in[s].z;
         if (reset) begin
            stage_ff[s].valid <= 1'b0;
         end else begin
            stage_ff[s].valid <= stage_in[s].valid;
         end
      end
   end

   assign out_stage = stage_ff[CORDIC_STAGES-1];

endmodule

// ===== hw/rtl/compass_heading_from_xy.sv =====
// ============================================================================
// compass_heading_from_xy: magnetometer heading from one X/Y reading pair
// Removes hard-iron offsets, takes atan2 with a pipelined CORDIC, turns the
// angle into an azimuth with declination and reports it in 1/64 degree.
// ============================================================================
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+---------------------------
//   request  | start, busy, req_x_reading, req_y_reading | taken when start && !busy
//   response | rsp_strobe, rsp_heading                 | one cycle, cannot be held
//   csr      | csr_we, csr_index, csr_wdata            | written when csr_we is high
//
// One item is accepted every clock cycle; busy is low except during reset
// and in the cycle after reset is released. Every item gives one result
// after passing the registers of offset subtraction, quadrant folding,
// one stage per CORDIC micro-rotation, then declination, wrap and rounding.
// Reset clears the pipeline valid bits and loads the offset and declination
// registers with their reset values. The receiver cannot stall, so the
// pipeline never stops and needs no buffering.
//
module compass_heading_from_xy
   import chfx_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // Request channel.
   input  logic                        start,
   output logic                        busy,
   input  logic signed [READING_W-1:0] req_x_reading,
   input  logic signed [READING_W-1:0] req_y_reading,
   // Response channel.
   output logic                        rsp_strobe,
   output logic        [HEADING_W-1:0] rsp_heading,
   // Configuration port.
   input  logic                        csr_we,
   input  logic        [1:0]           csr_index,
   input  logic        [DATA_W-1:0]    csr_wdata
);

   // Configuration registers.
   logic signed [OFFSET_W-1:0] x_offset_ff;
   logic signed [OFFSET_W-1:0] y_offset_ff;
   logic signed [DECL_W-1:0]   decl_ff;

   // Busy only while coming out of reset.
   logic busy_ff;
   logic accept;

   // Stage 0: offset-corrected vector.
   logic                     s0_valid_ff;
   logic signed [DIFF_W-1:0] s0_dx_ff;
   logic signed [DIFF_W-1:0] s0_dy_ff;
   logic signed [DIFF_W-1:0] s0_dx_in;
   logic signed [DIFF_W-1:0] s0_dy_in;

   // Stage 1: folded vector into the right half plane, start angle.
   chfx_stage_type s1_stage_ff;
   chfx_stage_type s1_stage_in;
   logic signed [DIFF_W:0] neg_x;
   logic signed [DIFF_W:0] neg_y;
   logic signed [DIFF_W:0] sel_x;
   logic signed [DIFF_W:0] sel_y;

   chfx_stage_type cordic_out;

   // Post stages: offset/declination, wrap, rounding.
   logic                  p1_valid_ff;
   logic signed [T_W-1:0] p1_t_ff;
   logic signed [T_W-1:0] p1_t_in;
   logic                  p2_valid_ff;
   logic signed [T_W-1:0] p2_t_ff;
   logic signed [T_W-1:0] p2_t_in;
   logic signed [T_W-1:0] rounded;
   logic                  rsp_strobe_ff;
   logic [HEADING_W-1:0]  rsp_heading_ff;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // ----------------------------------------------------------------------
   // Configuration writes. Indexes beyond the register list are ignored.
   // ----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         x_offset_ff <= X_OFFSET_RST;
         y_offset_ff <= Y_OFFSET_RST;
         decl_ff     <= DECL_RST;
         busy_ff     <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            case (chfx_csr_type'(csr_index))
               CSR_X_OFFSET:    x_offset_ff <= csr_wdata[OFFSET_W-1:0];
               CSR_Y_OFFSET:    y_offset_ff <= csr_wdata[OFFSET_W-1:0];
               CSR_DECLINATION: decl_ff     <= csr_wdata[DECL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // ----------------------------------------------------------------------
   // Stage 0: subtract the hard-iron offsets. The 14-bit difference cannot
   // overflow for any reading and offset.
   // ----------------------------------------------------------------------
   assign s0_dx_in = {req_x_reading[READING_W-1], req_x_reading}
                   - {{(DIFF_W-OFFSET_W){x_offset_ff[OFFSET_W-1]}}, x_offset_ff};
   assign s0_dy_in = {req_y_reading[READING_W-1], req_y_reading}
                   - {{(DIFF_W-OFFSET_W){y_offset_ff[OFFSET_W-1]}}, y_offset_ff};

   always_ff @(posedge clock) begin
      s0_dx_ff <= s0_dx_in;
      s0_dy_ff <= s0_dy_in;
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
   end

   // ----------------------------------------------------------------------
   // Stage 1: the axes give exact angles and bypass the rotations. A vector
   // in the left half plane is negated and starts at +180 or -180 degrees
   // so the CORDIC only sees angles within its convergence range.
   // ----------------------------------------------------------------------
   assign neg_x = '0 - {s0_dx_ff[DIFF_W-1], s0_dx_ff};
   assign neg_y = '0 - {s0_dy_ff[DIFF_W-1], s0_dy_ff};

   always_comb begin
      s1_stage_in       = '0;
      s1_stage_in.valid = s0_valid_ff;
      sel_x             = {s0_dx_ff[DIFF_W-1], s0_dx_ff};
      sel_y             = {s0_dy_ff[DIFF_W-1], s0_dy_ff};
      if (s0_dy_ff == '0) begin
         s1_stage_in.fixed = 1'b1;
         s1_stage_in.z     = s0_dx_ff[DIFF_W-1] ? Z_DEG_180 : '0;
      end else if (s0_dx_ff == '0) begin
         s1_stage_in.fixed = 1'b1;
         s1_stage_in.z     = s0_dy_ff[DIFF_W-1] ? -Z_DEG_90 : Z_DEG_90;
      end else if (s0_dx_ff[DIFF_W-1]) begin
         s1_stage_in.z = s0_dy_ff[DIFF_W-1] ? -Z_DEG_180 : Z_DEG_180;
         sel_x         = neg_x;
         sel_y         = neg_y;
      end
      s1_stage_in.x = {{(VEC_W-DIFF_W-1-VEC_FRAC){sel_x[DIFF_W]}}, sel_x,
                       {VEC_FRAC{1'b0}}};
      s1_stage_in.y = {{(VEC_W-DIFF_W-1-VEC_FRAC){sel_y[DIFF_W]}}, sel_y,
                       {VEC_FRAC{1'b0}}};
   end

   always_ff @(posedge clock) begin
      s1_stage_ff.fixed <= s1_stage_in.fixed;
      s1_stage_ff.x     <= s1_stage_in.x;
      s1_stage_ff.y     <= s1_stage_in.y;
      s1_stage_ff.z     <= s1_stage_in.z;
      if (reset) begin
         s1_stage_ff.valid <= 1'b0;
      end else begin
         s1_stage_ff.valid <= s1_stage_in.valid;
      end
   end

   chfx_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (s1_stage_ff),
      .out_stage (cordic_out)
   );

   // ----------------------------------------------------------------------
   // Post stage 1: turn the angle into an azimuth and add the declination,
   // scaled up exactly into the fine angle units.
   // ----------------------------------------------------------------------
   assign p1_t_in = {{(T_W-Z_W){cordic_out.z[Z_W-1]}}, cordic_out.z} - T_DEG_90
                  + ({{(T_W-DECL_W){decl_ff[DECL_W-1]}}, decl_ff} <<< OUT_SHIFT);

   // Post stage 2: a single wrap by 360 degrees toward 0..360; a declination below -90 degrees can leave it negative.
   always_comb begin
      p2_t_in = p1_t_ff;
      if (p1_t_ff[T_W-1]) begin
         p2_t_in = p1_t_ff + T_DEG_360;
      end else if (p1_t_ff > T_DEG_360) begin
         p2_t_in = p1_t_ff - T_DEG_360;
      end
   end

   // Post stage 3: round half up to the output resolution; the field keeps
   // the low bits of the shifted value.
   assign rounded = p2_t_ff + T_ROUND;

   always_ff @(posedge clock) begin
      p1_t_ff        <= p1_t_in;
      p2_t_ff        <= p2_t_in;
      rsp_heading_ff <= rounded[OUT_SHIFT+HEADING_W-1:OUT_SHIFT];
      if (reset) begin
         p1_valid_ff   <= 1'b0;
         p2_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         p1_valid_ff   <= cordic_out.valid;
         p2_valid_ff   <= p1_valid_ff;
         rsp_strobe_ff <= p2_valid_ff;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_heading = rsp_heading_ff;

   // ----------------------------------------------------------------------
   // Checks.
   // ----------------------------------------------------------------------
   // Every accepted item comes out after the fixed pipeline latency.
   a_item_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted item produced no result at the pipeline latency");

   // No result without an item accepted exactly one latency earlier.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching accepted item");

   // The block stays ready once out of reset.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !busy)
      else $error("busy raised outside of reset recovery");

   // Values after the wrap stage never exceed 360 degrees plus one turn.
   a_wrap_bound: assert property (@(posedge clock) disable iff (reset)
      p2_valid_ff |-> (p2_t_ff <= T_DEG_360 + T_DEG_360))
      else $error("wrapped heading out of bounds");

endmodule

// ===== test/chfx_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// chfx_checker: heading predictor and result checker
// Watches the request, response and register ports of the compass heading
// block, predicts the heading of every accepted item and compares each
// result strobe against the oldest outstanding prediction.
// ============================================================================
module chfx_checker
   import chfx_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic signed [READING_W-1:0] req_x_reading,
   input  logic signed [READING_W-1:0] req_y_reading,
   input  logic                        rsp_strobe,
   input  logic        [HEADING_W-1:0] rsp_heading,
   input  logic                        csr_we,
   input  logic        [1:0]           csr_index,
   input  logic        [DATA_W-1:0]    csr_wdata,
   output int                          pending,
   output int                          mismatches,
   output int                          checked
);

   // Angles are carried as degrees times 2^24, vectors as integers times 2^20.
   localparam int     FINE_BITS  = 24;
   localparam int     VEC_BITS   = 20;
   localparam int     HEAD_SHIFT = FINE_BITS - ANGLE_FRAC_BITS;
   localparam longint FINE_DEG   = longint'(1) << FINE_BITS;

   typedef struct {
      logic signed [READING_W-1:0] x;
      logic signed [READING_W-1:0] y;
      logic        [HEADING_W-1:0] heading;
   } heading_entry_type;

   heading_entry_type expected_headings[$];
   longint            x_off;
   longint            y_off;
   longint            decl;

   // atan(2^-i) in degrees times 2^24, rounded to nearest.
   function automatic longint atan_step_deg(input int i);
      case (i)
         0:       return 754974720;
         1:       return 445687602;
         2:       return 235489088;
         3:       return 119537938;
         4:       return 60000934;
         5:       return 30029717;
         6:       return 15018523;
         7:       return 7509720;
         8:       return 3754917;
         9:       return 1877466;
         10:      return 938734;
         11:      return 469367;
         12:      return 234684;
         13:      return 117342;
         14:      return 58671;
         15:      return 29335;
         16:      return 14668;
         17:      return 7334;
         18:      return 3667;
         19:      return 1833;
         20:      return 917;
         21:      return 458;
         22:      return 229;
         23:      return 115;
         default: return 0;
      endcase
   endfunction

   // Vectoring CORDIC angle of (x, y), in (-180, 180] degrees times 2^24.
   function automatic longint vector_angle(input longint vx, input longint vy);
      longint z;
      longint cx;
      longint cy;
      longint nx;
      z = 0;
      if (vy == 0) begin
         return (vx < 0) ? 180 * FINE_DEG : 0;
      end
      if (vx == 0) begin
         return (vy > 0) ? 90 * FINE_DEG : -90 * FINE_DEG;
      end
      if (vx < 0) begin
         z  = (vy > 0) ? 180 * FINE_DEG : -180 * FINE_DEG;
         vx = -vx;
         vy = -vy;
      end
      cx = vx * (longint'(1) << VEC_BITS);
      cy = vy * (longint'(1) << VEC_BITS);
      for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
         if (cy > 0) begin
            nx = cx + (cy >>> i);
            cy = cy - (cx >>> i);
            z  = z + atan_step_deg(i);
         end else begin
            nx = cx - (cy >>> i);
            cy = cy + (cx >>> i);
            z  = z - atan_step_deg(i);
         end
         cx = nx;
      end
      return z;
   endfunction

   function automatic logic [HEADING_W-1:0] predict_heading(
      input logic signed [READING_W-1:0] xr,
      input logic signed [READING_W-1:0] yr
   );
      longint t;
      t = vector_angle(xr - x_off, yr - y_off) - 90 * FINE_DEG;
      t = t + decl * (longint'(1) << HEAD_SHIFT);
      if (t < 0) begin
         t = t + 360 * FINE_DEG;
      end
      if (t > 360 * FINE_DEG) begin
         t = t - 360 * FINE_DEG;
      end
      t = t + (longint'(1) << (HEAD_SHIFT - 1));
      t = t >>> HEAD_SHIFT;
      return t[HEADING_W-1:0];
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("[%0t] %s", $realtime, msg);
      end
   endtask

   always @(posedge clock) begin
      heading_entry_type e;
      if (reset) begin
         x_off = X_OFFSET_RST;
         y_off = Y_OFFSET_RST;
         decl  = DECL_RST;
         expected_headings.delete();
      end else begin
         if (start && !busy) begin
            e.x       = req_x_reading;
            e.y       = req_y_reading;
            e.heading = predict_heading(req_x_reading, req_y_reading);
            expected_headings.push_back(e);
         end
         if (rsp_strobe) begin
            if (expected_headings.size() == 0) begin
               note_mismatch($sformatf("heading %0d with no item outstanding", rsp_heading));
            end else begin
               e = expected_headings.pop_front();
               checked++;
               if (rsp_heading !== e.heading) begin
                  note_mismatch($sformatf("heading for x=%0d y=%0d: expected %0d, got %0d",
                                          e.x, e.y, e.heading, rsp_heading));
               end
            end
         end
         // Indexes past the register list are ignored.
         if (csr_we) begin
            case (csr_index)
               CSR_X_OFFSET:    x_off = $signed(csr_wdata[OFFSET_W-1:0]);
               CSR_Y_OFFSET:    y_off = $signed(csr_wdata[OFFSET_W-1:0]);
               CSR_DECLINATION: decl  = $signed(csr_wdata[DECL_W-1:0]);
               default: ;
            endcase
         end
      end
      pending <= expected_headings.size();
   end

endmodule

// ===== test/tb_compass_heading_from_xy.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_compass_heading_from_xy: testbench of the compass heading block
// Drives X/Y reading pairs through the request port under several offset
// and declination settings and sender idle rates; a checker beside the block
// predicts every heading and counts mismatches for the final verdict.
// ============================================================================
module tb_compass_heading_from_xy;
   import chfx_pkg::*;

   // Longest stretch without any accepted item or result before giving up.
   // A correct run never goes quiet for more than a drain plus a pause.
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int PHASE_ITEMS     = 192;
   localparam int NUM_PHASES      = 8;
   // The block has three registers; index three must be ignored.
   localparam logic [1:0] CSR_SPARE_INDEX = 2'd3;

   logic                        clock         = 1'b0;
   logic                        reset         = 1'b1;
   logic                        start         = 1'b0;
   logic                        busy;
   logic signed [READING_W-1:0] req_x_reading = '0;
   logic signed [READING_W-1:0] req_y_reading = '0;
   logic                        rsp_strobe;
   logic        [HEADING_W-1:0] rsp_heading;
   logic                        csr_we        = 1'b0;
   logic        [1:0]           csr_index     = '0;
   logic        [DATA_W-1:0]    csr_wdata     = '0;

   int pending_headings;
   int mismatches;
   int checked;
   int items_sent = 0;
   int quiet_cycles = 0;

   // The offsets currently programmed, so that random items can be aimed at
   // the zero vector and the axes of the corrected reading.
   logic signed [OFFSET_W-1:0] cur_x_off = X_OFFSET_RST;
   logic signed [OFFSET_W-1:0] cur_y_off = Y_OFFSET_RST;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   compass_heading_from_xy i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_x_reading (req_x_reading),
      .req_y_reading (req_y_reading),
      .rsp_strobe    (rsp_strobe),
      .rsp_heading   (rsp_heading),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   chfx_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_x_reading (req_x_reading),
      .req_y_reading (req_y_reading),
      .rsp_strobe    (rsp_strobe),
      .rsp_heading   (rsp_heading),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .pending       (pending_headings),
      .mismatches    (mismatches),
      .checked       (checked)
   );

   // The watchdog restarts on every accepted item and every result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d quiet cycles", quiet_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Presents one item and holds it until the block takes it. Before that,
   // the sender idles with the given chance per cycle; the ports carry noise
   // while start is low. start is assigned once per time step, so an item
   // that follows another directly keeps start high without a glitch.
   task automatic send_item(input logic signed [READING_W-1:0] x,
                            input logic signed [READING_W-1:0] y,
                            input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start         <= 1'b0;
         req_x_reading <= READING_W'($urandom);
         req_y_reading <= READING_W'($urandom);
         @(posedge clock);
      end
      start         <= 1'b1;
      req_x_reading <= x;
      req_y_reading <= y;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // Stops sending until every outstanding heading has come back, then lets
   // the pipeline run empty for a little longer than its latency. The
   // pending count is registered, so the first edge is always waited.
   task automatic drain;
      start <= 1'b0;
      do @(posedge clock); while (pending_headings != 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Writes all three registers, then the spare index with noise. The
   // offsets carry random bits above their width, which must be dropped.
   task automatic set_config(input logic signed [OFFSET_W-1:0] x_off,
                             input logic signed [OFFSET_W-1:0] y_off,
                             input logic signed [DECL_W-1:0]   decl);
      logic [DATA_W-OFFSET_W-1:0] junk;
      junk      = (DATA_W-OFFSET_W)'($urandom);
      csr_we    <= 1'b1;
      csr_index <= CSR_X_OFFSET;
      csr_wdata <= {junk, x_off};
      @(posedge clock);
      junk      = (DATA_W-OFFSET_W)'($urandom);
      csr_index <= CSR_Y_OFFSET;
      csr_wdata <= {junk, y_off};
      @(posedge clock);
      csr_index <= CSR_DECLINATION;
      csr_wdata <= decl;
      @(posedge clock);
      csr_index <= CSR_SPARE_INDEX;
      csr_wdata <= DATA_W'($urandom);
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_x_off = x_off;
      cur_y_off = y_off;
   endtask

   function automatic logic signed [READING_W-1:0] pick_extreme;
      case ($urandom_range(4))
         0:       return -13'sd4096;
         1:       return 13'sd2047;
         2:       return -13'sd4095;
         3:       return -13'sd1;
         default: return 13'sd0;
      endcase
   endfunction

   initial begin
      int                          idle_pct;
      int                          sel;
      logic signed [READING_W-1:0] x;
      logic signed [READING_W-1:0] y;
      logic signed [DECL_W-1:0]    decl;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed items under the reset offsets (10, -182) and no declination.
      // The first item also meets the busy cycle right after reset.
      send_item(10, -182, 0);        // zero vector after offset removal
      send_item(510, -182, 0);       // corrected Y zero, X positive
      send_item(-490, -182, 0);      // corrected Y zero, X negative
      send_item(-4096, -182, 0);     // overflow code on the negative X axis
      send_item(10, 818, 0);         // corrected X zero, Y positive
      send_item(10, -1182, 0);       // corrected X zero, Y negative
      send_item(-790, 618, 0);       // left half plane, upper side
      send_item(-790, -982, 0);      // left half plane, lower side
      send_item(1010, 818, 0);       // exact diagonal
      send_item(11, -181, 0);        // one-LSB diagonals around the zero vector
      send_item(9, -183, 0);
      send_item(11, -183, 0);
      send_item(9, -181, 0);
      send_item(-4096, -4096, 0);    // field extremes and overflow codes
      send_item(-4096, 2047, 0);
      send_item(2047, -4096, 0);
      send_item(2047, 2047, 0);
      send_item(-1, -1, 0);
      send_item(0, 0, 0);
      drain();

      // Random phases. Each one sets the registers while the block is idle
      // and then streams items. The receiver cannot stall this block, so the
      // phases differ in their register settings and in how often the sender idles.
      for (int ph = 1; ph <= NUM_PHASES; ph++) begin
         case (ph)
            1: begin
               set_config(-12'sd2048, 12'sd2047, 14'sd5760);
               idle_pct = 0;
            end
            2: begin
               set_config(12'sd2047, -12'sd2048, -14'sd5760);
               idle_pct = 47;
            end
            3: begin
               decl = DECL_W'($urandom_range(11520) - 5760);
               set_config(OFFSET_W'($urandom), OFFSET_W'($urandom), decl);
               idle_pct = 0;
            end
            4: begin
               set_config(12'sd0, 12'sd0, 14'sd0);
               idle_pct = 26;
            end
            5: begin
               // Declination past +90 degrees, which one wrap still covers.
               set_config(OFFSET_W'($urandom), OFFSET_W'($urandom), 14'sd8191);
               idle_pct = 47;
            end
            6: begin
               set_config(OFFSET_W'($urandom), OFFSET_W'($urandom), -14'sd8192);
               idle_pct = 26;
            end
            7: begin
               set_config(X_OFFSET_RST, Y_OFFSET_RST, DECL_RST);
               idle_pct = 0;
            end
            default: begin
               decl = DECL_W'($urandom_range(11520) - 5760);
               set_config(OFFSET_W'($urandom), OFFSET_W'($urandom), decl);
               idle_pct = 47;
            end
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            sel = $urandom_range(99);
            if (sel < 60) begin
               x = READING_W'($urandom);
               y = READING_W'($urandom);
            end else if (sel < 80) begin
               // Close to the offsets: hits the zero vector and both axes.
               x = READING_W'(cur_x_off + $signed($urandom_range(8)) - 4);
               y = READING_W'(cur_y_off + $signed($urandom_range(8)) - 4);
            end else begin
               x = ($urandom_range(1) == 0) ? pick_extreme() : READING_W'($urandom);
               y = pick_extreme();
            end
            send_item(x, y, idle_pct);
         end
         drain();
      end

      if (pending_headings != 0) begin
         $display("%0d headings never arrived", pending_headings);
      end
      $display("Sent %0d items and checked %0d headings over %0d register settings,",
               items_sent, checked, NUM_PHASES + 1);
      $display("with the sender idle at 0, 26 and 47 percent; %0d mismatches.", mismatches);
      if (mismatches == 0 && pending_headings == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
